>>> hdl/bfg_pkg.sv
// ----------------------------------------------------------------------------
// Battery fuel gauge package
// Widths, reset values, the discharge curve and the divider request types.
// ----------------------------------------------------------------------------
package bfg_pkg;

  localparam int MV_W       = 13;
  localparam int PCT_W      = 7;
  localparam int CNT_W      = 2;
  localparam int REF_POINTS = 8;
  localparam int IDX_W      = $clog2(REF_POINTS);
  localparam int SUM_W      = 15;   // sum of three 13-bit samples
  localparam int DSR_W      = 8;    // widest divisor: curve span or sample count
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  localparam logic [MV_W-1:0]  ABSENT_RESET      = 13'd4300;
  localparam logic [MV_W-1:0]  MIN_VALID_RESET   = 13'd100;
  localparam logic [CNT_W-1:0] REST_PERIOD_RESET = 2'd3;
  localparam logic [PCT_W-1:0] REST_CAP_PERCENT  = 7'd99;
  localparam logic [PCT_W-1:0] DONE_PERCENT      = 7'd100;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ABSENT      = 2'd0;
  localparam logic [1:0] REG_MIN_VALID   = 2'd1;
  localparam logic [1:0] REG_REST_PERIOD = 2'd2;

  // Discharge curve, highest voltage first
  localparam logic [MV_W-1:0] CURVE_MV [REF_POINTS] = '{
    13'd4200, 13'd4000, 13'd3900, 13'd3700,
    13'd3600, 13'd3500, 13'd3400, 13'd3300
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [REF_POINTS] = '{
    7'd100, 7'd85, 7'd60, 7'd40, 7'd20, 7'd10, 7'd5, 7'd0
  };

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  // Lower end of the curve segment that holds mv (smallest i with mv above point i)
  function automatic logic [IDX_W-1:0] seg_find(input logic [MV_W-1:0] mv);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = REF_POINTS - 1; i >= 1; i--) begin
      if (mv > CURVE_MV[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

>>> hdl/battery_fuel_gauge.sv
// ----------------------------------------------------------------------------
// Battery fuel gauge
// Averages valid voltage samples and maps the average onto a state of charge.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. The output register loads after a hold or
// error beat is accepted, after the averaging division for an averaged beat
// (absent battery included), and after the multiply step and curve division
// for an interpolated one, but not while an earlier result stalls; the next
// beat can be accepted once it has loaded. Both divisions run on one shared
// restoring divider at one quotient bit per cycle. s_axis_tready is high only
// while the sequencer is idle; a finished beat waits in the output register
// and does not block the next input beat. No clearing pass after reset.
module battery_fuel_gauge
  import bfg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // sample_first, sample_second, sample_third
  input  logic [2:0]  s_axis_tuser,  // charger_on, charge_done, read_failed
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // voltage_mv, battery_percent
  output logic [2:0]  m_axis_tuser   // values_updated, charger_pause, gauge_error
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIVA   = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIVP   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]       state_q;
  logic [MV_W-1:0]  absent_q, min_valid_q;
  logic [CNT_W-1:0] period_q, cnt_q;
  logic [MV_W-1:0]  cached_mv_q;
  logic [PCT_W-1:0] cached_pct_q;
  logic             chg_q, done_q, upd_q, pause_q, err_q, out_valid_q;
  logic [MV_W-1:0]  avg_q;
  logic [IDX_W-1:0] lo_q;
  logic [23:0]      out_data_q;
  logic [2:0]       out_user_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic             accept, cfg_wr;
  logic [MV_W-1:0]  smp0, smp1, smp2;
  logic             vld0, vld1, vld2;
  logic [SUM_W-1:0] sum_in;
  logic [CNT_W-1:0] count_in;
  logic             chg_in, hold_in, failed_in;
  logic [IDX_W-1:0] lo_hi;
  logic [DSR_W-1:0] seg_diff, seg_span;
  logic [PCT_W-1:0] seg_rise, pct_interp, pct_final;
  logic [SUM_W-1:0] avg_full;
  logic             out_load;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_ABSENT:      prdata = {19'd0, absent_q};
      REG_MIN_VALID:   prdata = {19'd0, min_valid_q};
      REG_REST_PERIOD: prdata = {30'd0, period_q};
      default:         prdata = '0;
    endcase
  end

  // input decode
  assign smp0      = s_axis_tdata[12:0];
  assign smp1      = s_axis_tdata[25:13];
  assign smp2      = s_axis_tdata[38:26];
  assign vld0      = smp0 > min_valid_q;
  assign vld1      = smp1 > min_valid_q;
  assign vld2      = smp2 > min_valid_q;
  assign sum_in    = (vld0 ? SUM_W'(smp0) : '0) + (vld1 ? SUM_W'(smp1) : '0)
                   + (vld2 ? SUM_W'(smp2) : '0);
  assign count_in  = CNT_W'({1'b0, vld0}) + CNT_W'({1'b0, vld1}) + CNT_W'({1'b0, vld2});
  assign chg_in    = s_axis_tuser[0] && !s_axis_tuser[1];
  assign hold_in   = chg_in && (cnt_q != '0);
  assign failed_in = s_axis_tuser[2];

  assign s_axis_tready = state_q == ST_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // curve segment terms
  assign lo_hi      = lo_q - IDX_W'(1);
  assign seg_diff   = DSR_W'(avg_q - CURVE_MV[lo_q]);
  assign seg_span   = DSR_W'(CURVE_MV[lo_hi] - CURVE_MV[lo_q]);
  assign seg_rise   = CURVE_PCT[lo_hi] - CURVE_PCT[lo_q];
  assign pct_interp = CURVE_PCT[lo_q] + div_rsp.quotient[PCT_W-1:0];
  assign pct_final  = (chg_q && pct_interp > REST_CAP_PERCENT) ? REST_CAP_PERCENT
                                                                : pct_interp;
  assign avg_full   = div_rsp.quotient;

  always_comb begin
    div_req.start    = (accept && !hold_in && !failed_in && count_in != '0)
                     || state_q == ST_MUL;
    div_req.dividend = sum_in;
    div_req.divisor  = DSR_W'(count_in);
    if (state_q == ST_MUL) begin
      div_req.dividend = SUM_W'(seg_diff) * SUM_W'(seg_rise);
      div_req.divisor  = seg_span;
    end
  end

  bfg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      absent_q     <= ABSENT_RESET;
      min_valid_q  <= MIN_VALID_RESET;
      period_q     <= REST_PERIOD_RESET;
      cnt_q        <= '0;
      cached_mv_q  <= '0;
      cached_pct_q <= '0;
      chg_q        <= 1'b0;
      done_q       <= 1'b0;
      upd_q        <= 1'b0;
      pause_q      <= 1'b0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_ABSENT:      absent_q    <= pwdata[MV_W-1:0];
          REG_MIN_VALID:   min_valid_q <= pwdata[MV_W-1:0];
          REG_REST_PERIOD: period_q    <= pwdata[CNT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            chg_q   <= chg_in;
            done_q  <= s_axis_tuser[1];
            upd_q   <= 1'b0;
            pause_q <= 1'b0;
            err_q   <= 1'b0;
            if (hold_in) begin
              cnt_q   <= cnt_q - CNT_W'(1);
              state_q <= ST_RESULT;
            end else begin
              if (chg_in) begin
                // reload; a period of zero samples every charging beat
                cnt_q   <= (period_q == '0) ? '0 : period_q - CNT_W'(1);
                pause_q <= 1'b1;
              end else begin
                cnt_q <= '0;
              end
              if (failed_in || count_in == '0) begin
                err_q   <= 1'b1;
                state_q <= ST_RESULT;
              end else begin
                state_q <= ST_DIVA;
              end
            end
          end
        end
        ST_DIVA: begin
          if (div_rsp.done) begin
            upd_q <= 1'b1;
            if (avg_full > SUM_W'(absent_q)) begin
              cached_mv_q  <= '0;
              cached_pct_q <= '0;
              state_q      <= ST_RESULT;
            end else begin
              cached_mv_q <= avg_full[MV_W-1:0];
              if (!chg_q && done_q) begin
                cached_pct_q <= DONE_PERCENT;
                state_q      <= ST_RESULT;
              end else if (avg_full[MV_W-1:0] > CURVE_MV[0]) begin
                cached_pct_q <= chg_q ? REST_CAP_PERCENT : DONE_PERCENT;
                state_q      <= ST_RESULT;
              end else if (avg_full[MV_W-1:0] <= CURVE_MV[REF_POINTS-1]) begin
                cached_pct_q <= '0;
                state_q      <= ST_RESULT;
              end else begin
                state_q <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: state_q <= ST_DIVP;
        ST_DIVP: begin
          if (div_rsp.done) begin
            cached_pct_q <= pct_final;
            state_q      <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_load) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIVA && div_rsp.done) begin
      avg_q <= avg_full[MV_W-1:0];
      lo_q  <= seg_find(avg_full[MV_W-1:0]);
    end
    if (out_load) begin
      out_data_q <= {4'd0, cached_pct_q, cached_mv_q};
      out_user_q <= {err_q, pause_q, upd_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> hdl/bfg_div.sv
// ----------------------------------------------------------------------------
// Battery fuel gauge divider
// Restoring divider, one quotient bit per cycle, shared by averaging and
// curve interpolation.
// ----------------------------------------------------------------------------
module bfg_div
  import bfg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [SUM_W-1:0]     quo_q;
  logic [DSR_W-1:0]     rem_q;
  logic [DSR_W-1:0]     dsr_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DSR_W:0]       trial;
  logic                 fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (req_i.start) begin
        cnt_q  <= DIV_CNT_W'(SUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q  <= cnt_q - DIV_CNT_W'(1);
        busy_q <= cnt_q != DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      // shift in one quotient bit, keep the partial remainder
      rem_q <= fits ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hdl/bfg_checker.sv
// ----------------------------------------------------------------------------
// Battery fuel gauge checker
// Port-level properties of the gauge, bound to the top level.
// ----------------------------------------------------------------------------
module bfg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // one beat at a time: the sequencer drops ready right after it takes a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready after an accepted beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result beat changed");

  a_err_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[2]))
    else $error("error beat marked as updated");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[19:13] <= 7'd100)
    else $error("percentage above 100");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[12:0] == 13'd0
      |-> m_axis_tdata[19:13] == 7'd0)
    else $error("absent battery with nonzero percentage");

endmodule

bind battery_fuel_gauge bfg_checker u_bfg_checker (.*);
